[rtl/core/ipv4p_pkg.sv]
`timescale 1ns / 1ps

package ipv4p_pkg;

    // Default number of entries in the queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // Character classes found by the front end.
    typedef enum logic [2:0] {
        CLS_DIGIT,
        CLS_HEX_LETTER,
        CLS_DOT,
        CLS_X,
        CLS_TERM,
        CLS_OTHER
    } char_class_t;

    // Parser phases.
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_START,
        PH_ZERO,
        PH_DIGITS
    } phase_t;

    // Number base of the part being collected.
    typedef enum logic [1:0] {
        BASE_DEC,
        BASE_OCT,
        BASE_HEX
    } base_t;

    // Error codes reported with each result.
    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_NO_DIGIT,
        ERR_TOO_MANY,
        ERR_TOO_BIG,
        ERR_BAD_TRAIL
    } err_t;

    // One classified character, as it waits in the queue.
    typedef struct packed {
        logic        first;
        char_class_t cls;
        logic [3:0]  value;
    } qitem_t;

    // One parse result.
    typedef struct packed {
        logic        ok;
        err_t        err;
        logic [31:0] address;
        logic [2:0]  count;
    } result_t;

endpackage

[rtl/core/ipv4_dotted_address_parser_core.sv]
`timescale 1ns / 1ps

// Channel   Direction  tdata (low bit first)                         tuser
// s_axis    in         char_code[7:0]                                first_char
// m_axis    out        ok, error_kind[2:0], address[31:0],           -
//                      part_count[2:0], one zero pad bit
//
// One character is taken per cycle while the queue is not full; the back end
// parses one per cycle while m_axis does not stall. A result is registered once
// the terminating or failing character leaves the queue. Reset is synchronous
// and empties the queue, clears parser state and the output valid flag. A stalled
// m_axis holds the result; characters enter until the QUEUE_DEPTH-entry queue fills.

module ipv4_dotted_address_parser_core #(
    parameter int QUEUE_DEPTH = ipv4p_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic        s_axis_tuser,    // [0] first_char
    input  logic [7:0]  s_axis_tdata,    // [7:0] char_code
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata     // [0] ok, [3:1] error_kind, [35:4] address,
                                         // [38:36] part_count, [39] zero
);

    ipv4p_pkg::qitem_t  push_item;
    ipv4p_pkg::qitem_t  pop_item;
    ipv4p_pkg::result_t result;
    logic               q_full;
    logic               q_push;
    logic               q_pop;
    logic               q_valid;

    ipv4p_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (push_item)
    );

    ipv4p_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_item  (pop_item)
    );

    ipv4p_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_item        (pop_item),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_result      (result)
    );

    // Pack the result fields, first field in the lowest bits.
    assign m_axis_tdata = {1'b0, result.count, result.address, result.err, result.ok};

endmodule

[rtl/core/ipv4p_front.sv]
`timescale 1ns / 1ps

module ipv4p_front (
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic               s_axis_tuser,   // [0] first_char
    input  logic [7:0]         s_axis_tdata,   // [7:0] char_code
    input  logic               q_full,
    output logic               q_push,
    output ipv4p_pkg::qitem_t  q_item
);

    logic [7:0] ch;

    assign ch            = s_axis_tdata;
    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;

    // Sort the character into a class and extract its digit value.
    always_comb begin
        q_item.first = s_axis_tuser;
        q_item.value = 4'd0;
        if (ch inside {[8'h30:8'h39]}) begin
            q_item.cls   = ipv4p_pkg::CLS_DIGIT;
            q_item.value = 4'(ch - 8'h30);
        end else if (ch inside {[8'h61:8'h66]}) begin
            q_item.cls   = ipv4p_pkg::CLS_HEX_LETTER;
            q_item.value = 4'(ch - 8'h57);
        end else if (ch inside {[8'h41:8'h46]}) begin
            q_item.cls   = ipv4p_pkg::CLS_HEX_LETTER;
            q_item.value = 4'(ch - 8'h37);
        end else if (ch == 8'h2E) begin
            q_item.cls = ipv4p_pkg::CLS_DOT;
        end else if (ch == 8'h78 || ch == 8'h58) begin
            q_item.cls = ipv4p_pkg::CLS_X;
        end else if (ch inside {8'h00, 8'h20, [8'h09:8'h0D]}) begin
            q_item.cls = ipv4p_pkg::CLS_TERM;
        end else begin
            q_item.cls = ipv4p_pkg::CLS_OTHER;
        end
    end

endmodule

[rtl/core/ipv4p_queue.sv]
`timescale 1ns / 1ps

module ipv4p_queue #(
    parameter int DEPTH = ipv4p_pkg::QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  ipv4p_pkg::qitem_t  push_item,
    output logic               full,
    input  logic               pop,
    output logic               pop_valid,
    output ipv4p_pkg::qitem_t  pop_item
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ipv4p_pkg::qitem_t  entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_item  = entry_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill count exceeds depth");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> pop_valid)
        else $error("queue popped while empty");

    a_push_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not follow a push");

endmodule

[rtl/core/ipv4p_back.sv]
`timescale 1ns / 1ps

module ipv4p_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  ipv4p_pkg::qitem_t  q_item,
    output logic               q_pop,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output ipv4p_pkg::result_t m_result
);

    ipv4p_pkg::phase_t  phase_reg, phase_next;
    ipv4p_pkg::base_t   base_reg, base_next;
    logic [31:0]        value_reg, value_next;
    logic [31:0]        saved_reg [3];
    logic [31:0]        save_data;
    logic               save_en;
    logic [1:0]         parts_reg, parts_next;
    logic               out_valid_reg, out_valid_next;
    ipv4p_pkg::result_t out_reg, out_next;

    // Working copies after a first-character restart.
    ipv4p_pkg::phase_t  ph;
    ipv4p_pkg::base_t   dbase;
    logic [31:0]        val;
    logic [1:0]         parts;
    logic [31:0]        shifted;
    logic [31:0]        high_bits;
    logic               too_big;
    logic               emit;

    assign q_pop         = q_valid && (!out_valid_reg || m_axis_tready);
    assign m_axis_tvalid = out_valid_reg;
    assign m_result      = out_reg;

    // Upper bytes from the saved parts, and range check of the last part.
    // Earlier parts are ORed in at bits 24, 16 and 8; the first keeps only its
    // low byte, but a large middle part spills into the bytes above it.
    always_comb begin
        high_bits = 32'd0;
        too_big   = 1'b0;
        case (parts)
            2'd1: begin
                high_bits = {saved_reg[0][7:0], 24'd0};
                too_big   = (val[31:24] != 8'd0);
            end
            2'd2: begin
                high_bits = {saved_reg[0][7:0], 24'd0} | {saved_reg[1][15:0], 16'd0};
                too_big   = (val[31:16] != 16'd0);
            end
            2'd3: begin
                high_bits = {saved_reg[0][7:0], 24'd0} | {saved_reg[1][15:0], 16'd0}
                          | {saved_reg[2][23:0], 8'd0};
                too_big   = (val[31:8] != 24'd0);
            end
            default: begin
                high_bits = 32'd0;
                too_big   = 1'b0;
            end
        endcase
    end

    // Parser step for one classified character.
    always_comb begin
        ph    = q_item.first ? ipv4p_pkg::PH_START : phase_reg;
        dbase = q_item.first ? ipv4p_pkg::BASE_DEC : base_reg;
        val   = q_item.first ? 32'd0 : value_reg;
        parts = q_item.first ? 2'd0 : parts_reg;

        phase_next = ph;
        base_next  = dbase;
        value_next = val;
        parts_next = parts;
        save_en    = 1'b0;
        save_data  = val;
        emit       = 1'b0;
        out_next   = '{ok: 1'b0, err: ipv4p_pkg::ERR_NONE, address: 32'd0,
                       count: {1'b0, parts} + 3'd1};

        // A leading zero picks hex on x or X, otherwise octal.
        if (ph == ipv4p_pkg::PH_ZERO) begin
            dbase = (q_item.cls == ipv4p_pkg::CLS_X) ? ipv4p_pkg::BASE_HEX
                                                       : ipv4p_pkg::BASE_OCT;
            base_next = dbase;
        end

        case (dbase)
            ipv4p_pkg::BASE_HEX: shifted = {val[27:0], 4'd0};
            ipv4p_pkg::BASE_OCT: shifted = {val[28:0], 3'd0};
            default:             shifted = {val[28:0], 3'd0} + {val[30:0], 1'b0};
        endcase

        case (ph)
            ipv4p_pkg::PH_START: begin
                if (q_item.cls != ipv4p_pkg::CLS_DIGIT) begin
                    emit         = 1'b1;
                    out_next.err = ipv4p_pkg::ERR_NO_DIGIT;
                end else if (q_item.value == 4'd0) begin
                    value_next = 32'd0;
                    phase_next = ipv4p_pkg::PH_ZERO;
                end else begin
                    base_next  = ipv4p_pkg::BASE_DEC;
                    value_next = {28'd0, q_item.value};
                    phase_next = ipv4p_pkg::PH_DIGITS;
                end
            end
            ipv4p_pkg::PH_ZERO, ipv4p_pkg::PH_DIGITS: begin
                phase_next = ipv4p_pkg::PH_DIGITS;
                if (ph == ipv4p_pkg::PH_ZERO && q_item.cls == ipv4p_pkg::CLS_X) begin
                    value_next = val;
                end else if (q_item.cls == ipv4p_pkg::CLS_DIGIT ||
                             (q_item.cls == ipv4p_pkg::CLS_HEX_LETTER &&
                              dbase == ipv4p_pkg::BASE_HEX)) begin
                    value_next = shifted + {28'd0, q_item.value};
                end else if (q_item.cls == ipv4p_pkg::CLS_DOT) begin
                    if (parts == 2'd3) begin
                        emit           = 1'b1;
                        out_next.err   = ipv4p_pkg::ERR_TOO_MANY;
                        out_next.count = 3'd4;
                    end else begin
                        save_en    = 1'b1;
                        parts_next = parts + 2'd1;
                        phase_next = ipv4p_pkg::PH_START;
                    end
                end else if (q_item.cls == ipv4p_pkg::CLS_TERM) begin
                    emit = 1'b1;
                    if (too_big) begin
                        out_next.err = ipv4p_pkg::ERR_TOO_BIG;
                    end else begin
                        out_next.ok      = 1'b1;
                        out_next.address = val | high_bits;
                    end
                end else begin
                    emit         = 1'b1;
                    out_next.err = ipv4p_pkg::ERR_BAD_TRAIL;
                end
            end
            default: begin
                phase_next = ipv4p_pkg::PH_IDLE;
            end
        endcase

        if (emit) begin
            phase_next = ipv4p_pkg::PH_IDLE;
        end
    end

    // Output register valid: loaded on a result, cleared when taken.
    always_comb begin
        if (q_pop && emit) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= ipv4p_pkg::PH_IDLE;
            base_reg      <= ipv4p_pkg::BASE_DEC;
            value_reg     <= 32'd0;
            parts_reg     <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (q_pop) begin
                phase_reg <= phase_next;
                base_reg  <= base_next;
                value_reg <= value_next;
                parts_reg <= parts_next;
            end
        end
    end

    // Saved parts and result payload.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            saved_reg[0] <= 32'd0;
            saved_reg[1] <= 32'd0;
            saved_reg[2] <= 32'd0;
        end else if (q_pop && save_en) begin
            saved_reg[parts] <= save_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && emit) begin
            out_reg <= out_next;
        end
    end

    a_ok_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.ok) |->
            (out_reg.err == ipv4p_pkg::ERR_NONE && out_reg.count != 3'd0))
        else $error("successful result carries an error or no parts");

    a_err_zero_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_reg.ok) |->
            (out_reg.address == 32'd0 && out_reg.err != ipv4p_pkg::ERR_NONE))
        else $error("failed result carries an address or no error");

    a_idle_after_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && emit) |=> phase_reg == ipv4p_pkg::PH_IDLE)
        else $error("parser did not go idle after a result");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_axis_tready) |-> !q_pop)
        else $error("stalled result could be overwritten");

endmodule
